// ===== src/aspe_pkg.sv =====
// Package for the add/subtract expression evaluator.
// Holds the character codes, the status codes and the stack frame type.
// It depends on nothing else.
package aspe_pkg;

	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_NINE   = 8'h39;
	localparam logic [7:0] CHAR_PLUS   = 8'h2B;
	localparam logic [7:0] CHAR_MINUS  = 8'h2D;
	localparam logic [7:0] CHAR_LPAREN = 8'h28;
	localparam logic [7:0] CHAR_RPAREN = 8'h29;

	localparam int VALUE_W = 32;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TOO_DEEP  = 2'd1,
		ST_UNMATCHED = 2'd2
	} status_t;

	typedef struct packed {
		logic                 neg;
		logic [VALUE_W-1:0]   sum;
	} frame_t;

endpackage

// ===== src/add_sub_paren_expression_evaluator.sv =====
// Top level of the add/subtract expression evaluator with parentheses.
// Uses aspe_pkg for character codes, status codes and the stack frame type.
//
// The block takes one ASCII character per request, one request per clock
// cycle, and keeps accepting characters while a result waits to be taken. On
// the character marked last it loads a result register at the edge that
// accepts it and returns to its reset state at that same edge. The
// open-parenthesis stack lives in a synchronous memory with a registered read
// port; the top frame is held in a register and the frame below it is read
// ahead every cycle (with a bypass when it was written in the same cycle), so
// a close parenthesis pops without waiting on a memory read. The memory needs
// no clearing pass after reset, because only entries pushed since then are
// ever read. The input stalls only when a last character arrives while the
// previous result is still held.
module add_sub_paren_expression_evaluator #(
	parameter int STACK_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          char_code,
	input  logic                is_last,
	input  logic                in_valid,
	output logic                in_stall,
	output logic signed [31:0]  value,
	output logic [1:0]          status,
	output logic                out_valid,
	input  logic                out_stall
);
	import aspe_pkg::*;

	localparam int LW        = $clog2(STACK_DEPTH + 1);
	localparam int AW        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int MEM_DEPTH = 1 << AW;

	// Scalar state.
	logic [VALUE_W-1:0] sum_q, num_q;
	logic               neg_q;
	logic [LW-1:0]      level_q;
	status_t            err_q;
	frame_t             top_q;

	// Stack memory and its read-ahead path.
	frame_t             mem [MEM_DEPTH];
	frame_t             rd_q, fwd_data_q;
	logic               fwd_q;
	frame_t             below;

	// Output register.
	logic               out_valid_q;
	logic [VALUE_W-1:0] value_q;
	status_t            status_q;

	logic               acc;
	logic [VALUE_W-1:0] sum_d, num_d, fold_cur, fold_end;
	logic               neg_d;
	logic [LW-1:0]      level_d, level_next;
	status_t            err_d;
	frame_t             top_d;
	logic               push, we;
	logic [AW-1:0]      wr_addr, rd_addr;
	logic [LW-1:0]      rd_level;
	logic [3:0]         digit;

	assign in_stall  = out_valid_q && out_stall && is_last;
	assign acc       = in_valid && !in_stall;
	assign below     = fwd_q ? fwd_data_q : rd_q;
	assign digit     = 4'(char_code - CHAR_ZERO);
	assign fold_cur  = neg_q ? (sum_q - num_q) : (sum_q + num_q);

	always_comb begin
		sum_d   = sum_q;
		num_d   = num_q;
		neg_d   = neg_q;
		level_d = level_q;
		err_d   = err_q;
		top_d   = top_q;
		push    = 1'b0;
		priority if (char_code >= CHAR_ZERO && char_code <= CHAR_NINE) begin
			num_d = (num_q << 3) + (num_q << 1) + VALUE_W'(digit);
		end else if (char_code == CHAR_PLUS || char_code == CHAR_MINUS) begin
			sum_d = fold_cur;
			num_d = '0;
			neg_d = (char_code == CHAR_MINUS);
		end else if (char_code == CHAR_LPAREN) begin
			if (level_q < LW'(STACK_DEPTH)) begin
				push      = 1'b1;
				top_d.sum = sum_q;
				top_d.neg = neg_q;
				level_d   = level_q + LW'(1);
				sum_d     = '0;
				num_d     = '0;
				neg_d     = 1'b0;
			end else if (err_q == ST_OK) begin
				err_d = ST_TOO_DEEP;
			end
		end else if (char_code == CHAR_RPAREN) begin
			num_d = '0;
			neg_d = 1'b0;
			if (level_q != '0) begin
				level_d = level_q - LW'(1);
				sum_d   = top_q.neg ? (top_q.sum - fold_cur) : (top_q.sum + fold_cur);
				top_d   = below;
			end else begin
				sum_d = fold_cur;
				if (err_q == ST_OK) begin
					err_d = ST_UNMATCHED;
				end
			end
		end else begin
			sum_d = sum_q;
		end
		fold_end = neg_d ? (sum_d - num_d) : (sum_d + num_d);
	end

	// The old top frame moves into memory on a push from a non-zero level, one slot below the new top.
	assign we         = acc && push && (level_q != '0);
	assign wr_addr    = AW'(level_q - LW'(1));
	assign level_next = acc ? (is_last ? '0 : level_d) : level_q;
	assign rd_level   = level_next - LW'(2);
	assign rd_addr    = rd_level[AW-1:0];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= top_q;
		end
		rd_q       <= mem[rd_addr];
		fwd_data_q <= top_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else begin
			fwd_q <= we && (wr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			num_q   <= '0;
			neg_q   <= 1'b0;
			level_q <= '0;
			err_q   <= ST_OK;
		end else if (acc) begin
			if (is_last) begin
				sum_q   <= '0;
				num_q   <= '0;
				neg_q   <= 1'b0;
				level_q <= '0;
				err_q   <= ST_OK;
			end else begin
				sum_q   <= sum_d;
				num_q   <= num_d;
				neg_q   <= neg_d;
				level_q <= level_d;
				err_q   <= err_d;
			end
		end
	end

	// The top frame is payload: it is only read while the level is non-zero.
	always_ff @(posedge clk) begin
		if (acc && !is_last) begin
			top_q <= top_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc && is_last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && is_last) begin
			value_q  <= (err_d != ST_OK) ? '0 : fold_end;
			status_q <= err_d;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign status    = status_q;

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LW'(STACK_DEPTH))
		else $error("stack level beyond depth");

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_last) |=> (out_valid && level_q == '0 && err_q == ST_OK))
		else $error("last character did not give a result and clear state");

	a_error_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (value == '0))
		else $error("value not zero on error status");

	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall && !(acc && is_last)) |=> (out_valid && $stable(value)))
		else $error("stalled result lost or changed");

endmodule
